>>> hdl/spcd_pkg.sv
// Shared types and constants of the shape pair collision detector.
`timescale 1ns / 1ps

package spcd_pkg;

   // Width of the slot index fields on the result channel.
   localparam int IDX_W = 6;

   // Pair kind codes, in test priority order.
   localparam logic [1:0] KIND_CIRCLE_CIRCLE = 2'd0;
   localparam logic [1:0] KIND_BOX_BOX       = 2'd1;
   localparam logic [1:0] KIND_BOX_CIRCLE    = 2'd2;
   localparam logic [1:0] KIND_CIRCLE_BOX    = 2'd3;

   // One stored entity, as it sits in the entity table.
   typedef struct packed {
      logic               has_box;
      logic               has_circle;
      logic signed [15:0] x_pos;
      logic signed [15:0] y_pos;
      logic        [11:0] box_width;
      logic        [11:0] box_height;
      logic signed [11:0] circle_dx;
      logic signed [11:0] circle_dy;
      logic        [11:0] radius;
   } entity_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             load;
      logic             drop;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic [IDX_W-1:0] slot;
      logic             finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic pipe_empty;
   } status_type;

endpackage

>>> hdl/shape_pair_collision_detector.sv
// Top level of the shape pair collision detector.
`timescale 1ns / 1ps

// Broad-phase collision tester for one frame of entities.
// An entity item is accepted on a rising edge with start high and busy low. Its
// req_ ports carry the box and circle flags, the corner position, the box size,
// the circle offset and the radius. req_frame_start empties the table first.
// The entity takes the next table slot and is tested against every earlier
// entity of the frame, oldest first. Every colliding earlier entity gives one
// result item; rsp_last_of_run marks the final one. With no collision a single
// item with rsp_hit low is given; with a full table a single item with
// rsp_dropped set is given and the entity is neither tested nor stored.
// Each result item is shown for exactly one cycle with rsp_valid high; the
// receiver cannot stall, so no result is ever held back.
// Timing: the scan reads one stored entity per cycle from the single table
// read port into a four-stage test pipeline. Busy stays high while the scan
// runs and the pipeline drains, and the final result appears in the same
// cycle as busy falls. A dropped entity leaves busy low and its result
// appears in the next cycle.
// Synchronous reset empties the table and clears all control state.
module shape_pair_collision_detector
   import spcd_pkg::*;
#(
   parameter int MAX_ENTITIES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_frame_start,
   input  logic               req_has_box,
   input  logic               req_has_circle,
   input  logic signed [15:0] req_x_pos,
   input  logic signed [15:0] req_y_pos,
   input  logic        [11:0] req_box_width,
   input  logic        [11:0] req_box_height,
   input  logic signed [11:0] req_circle_dx,
   input  logic signed [11:0] req_circle_dy,
   input  logic        [11:0] req_radius,
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic         [5:0] rsp_earlier_index,
   output logic         [5:0] rsp_new_index,
   output logic         [1:0] rsp_pair_kind,
   output logic               rsp_dropped,
   output logic               rsp_last_of_run
);

   // Commands and status between the sequencer and the datapath.
   cmd_type    cmd;
   status_type status;

   // The controller owns the entity count and walks the table slots.
   spcd_ctrl #(
      .MAX_ENTITIES(MAX_ENTITIES)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_frame_start(req_frame_start),
      .busy           (busy),
      .cmd            (cmd),
      .status         (status)
   );

   // The datapath holds the table, runs the pair tests and forms the results.
   spcd_datapath #(
      .MAX_ENTITIES(MAX_ENTITIES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_has_box      (req_has_box),
      .req_has_circle   (req_has_circle),
      .req_x_pos        (req_x_pos),
      .req_y_pos        (req_y_pos),
      .req_box_width    (req_box_width),
      .req_box_height   (req_box_height),
      .req_circle_dx    (req_circle_dx),
      .req_circle_dy    (req_circle_dy),
      .req_radius       (req_radius),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_earlier_index(rsp_earlier_index),
      .rsp_new_index    (rsp_new_index),
      .rsp_pair_kind    (rsp_pair_kind),
      .rsp_dropped      (rsp_dropped),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

>>> hdl/spcd_ctrl.sv
// Controller of the shape pair collision detector: entity count and scan sequencing.
`timescale 1ns / 1ps

module spcd_ctrl
   import spcd_pkg::*;
#(
   parameter int MAX_ENTITIES = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       req_frame_start,
   output logic       busy,
   output cmd_type    cmd,
   input  status_type status
);

   localparam int AW = $clog2(MAX_ENTITIES);
   localparam int CW = $clog2(MAX_ENTITIES + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] k_ff, k_in;
   logic [AW-1:0] slot_ff, slot_in;

   logic          accept;
   logic          full;
   logic [CW-1:0] eff_count;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && (state_ff == ST_IDLE);
   assign eff_count = req_frame_start ? '0 : count_ff;
   assign full      = (eff_count >= CW'(MAX_ENTITIES));

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      k_in        = k_ff;
      slot_in     = slot_ff;
      cmd         = '0;
      cmd.rd_addr = IDX_W'(k_ff);
      cmd.slot    = IDX_W'(eff_count[AW-1:0]);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (full) begin
                  cmd.drop = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  count_in = CW'(eff_count + 1'b1);
                  slot_in  = eff_count[AW-1:0];
                  k_in     = '0;
                  state_in = (eff_count == '0) ? ST_WAIT : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            if (k_ff == AW'(slot_ff - 1'b1)) begin
               state_in = ST_WAIT;
            end else begin
               k_in = AW'(k_ff + 1'b1);
            end
         end
         ST_WAIT: begin
            if (status.pipe_empty) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         k_ff     <= '0;
         slot_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         k_ff     <= k_in;
         slot_ff  <= slot_in;
      end
   end

`ifndef SYNTHESIS
   // A dropped entity leaves the table and the controller untouched.
   assert property (@(posedge clock) disable iff (reset)
      (accept && full) |=> (state_ff == ST_IDLE) && (count_ff == $past(count_ff)))
      else $error("dropped entity changed controller state");

   // The table never holds more entities than it has slots.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTITIES))
      else $error("entity count beyond table depth");

   // The scan only reads slots below the new entity's slot.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (k_ff < slot_ff))
      else $error("scan read at or past the new slot");

   // A stored entity always raises busy in the cycle after it is accepted.
   assert property (@(posedge clock) disable iff (reset)
      (accept && !full) |=> busy)
      else $error("stored entity did not raise busy");
`endif

endmodule

>>> hdl/spcd_datapath.sv
// Datapath of the shape pair collision detector: entity table, pair test pipeline, results.
`timescale 1ns / 1ps

module spcd_datapath
   import spcd_pkg::*;
#(
   parameter int MAX_ENTITIES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               req_has_box,
   input  logic               req_has_circle,
   input  logic signed [15:0] req_x_pos,
   input  logic signed [15:0] req_y_pos,
   input  logic        [11:0] req_box_width,
   input  logic        [11:0] req_box_height,
   input  logic signed [11:0] req_circle_dx,
   input  logic signed [11:0] req_circle_dy,
   input  logic        [11:0] req_radius,
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic   [IDX_W-1:0] rsp_earlier_index,
   output logic   [IDX_W-1:0] rsp_new_index,
   output logic         [1:0] rsp_pair_kind,
   output logic               rsp_dropped,
   output logic               rsp_last_of_run
);

   localparam int AW = $clog2(MAX_ENTITIES);

   // Distance from a circle centre to the clamped point of a box span, on one axis.
   function automatic logic signed [17:0] clamp_gap(input logic signed [16:0] lo,
                                                    input logic signed [16:0] hi,
                                                    input logic signed [16:0] c);
      logic signed [17:0] d_lo;
      logic signed [17:0] d_hi;
      d_lo = 18'(lo) - 18'(c);
      d_hi = 18'(hi) - 18'(c);
      if (d_lo > 18'sd0) begin
         return d_lo;
      end else if (d_hi < 18'sd0) begin
         return d_hi;
      end
      return 18'sd0;
   endfunction

   entity_type table_mem [MAX_ENTITIES];

   // New entity, with its derived values.
   entity_type         ne_ff;
   logic signed [16:0] ne_cx_ff, ne_cy_ff, ne_xe_ff, ne_ye_ff;
   logic        [23:0] ne_r2_ff;
   logic    [AW-1:0]   ne_slot_ff;

   // Table read stage.
   entity_type    rd_ff;
   logic          v0_ff;
   logic [AW-1:0] idx0_ff;

   // Earlier entity derived values.
   logic               v1_ff;
   logic [AW-1:0]      idx1_ff;
   logic               e1_box_ff, e1_circ_ff;
   logic signed [15:0] e1_x_ff, e1_y_ff;
   logic signed [16:0] e1_cx_ff, e1_cy_ff, e1_xe_ff, e1_ye_ff;
   logic        [11:0] e1_r_ff;

   // Differences and span tests.
   logic               v2_ff;
   logic [AW-1:0]      idx2_ff;
   logic               e2_box_ff, e2_circ_ff, bb2_ff;
   logic signed [17:0] cc_dx_ff, cc_dy_ff, bc_dx_ff, bc_dy_ff, cb_dx_ff, cb_dy_ff;
   logic        [12:0] rsum_ff;
   logic        [11:0] e2_r_ff;

   // Squares.
   logic               v3_ff;
   logic [AW-1:0]      idx3_ff;
   logic               e3_box_ff, e3_circ_ff, bb3_ff;
   logic        [35:0] cc_sx_ff, cc_sy_ff, bc_sx_ff, bc_sy_ff, cb_sx_ff, cb_sy_ff;
   logic        [25:0] rs2_ff;
   logic        [23:0] er2_ff;

   // Held hit, waiting to learn whether it is the last of the run.
   logic          pend_valid_ff, pend_valid_in;
   logic [AW-1:0] pend_idx_ff, pend_idx_in;
   logic    [1:0] pend_kind_ff, pend_kind_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_hit_ff, rsp_hit_in;
   logic [IDX_W-1:0] rsp_ei_ff, rsp_ei_in;
   logic [IDX_W-1:0] rsp_ni_ff, rsp_ni_in;
   logic       [1:0] rsp_kind_ff, rsp_kind_in;
   logic             rsp_drop_ff, rsp_drop_in;
   logic             rsp_last_ff, rsp_last_in;

   logic       cc_hit, bb_hit, bc_hit, cb_hit, pair_hit;
   logic [1:0] pair_kind;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         table_mem[cmd.slot[AW-1:0]] <= {req_has_box, req_has_circle, req_x_pos, req_y_pos,
                                         req_box_width, req_box_height, req_circle_dx,
                                         req_circle_dy, req_radius};
         ne_ff      <= {req_has_box, req_has_circle, req_x_pos, req_y_pos,
                        req_box_width, req_box_height, req_circle_dx,
                        req_circle_dy, req_radius};
         ne_cx_ff   <= 17'(req_x_pos) + 17'(req_circle_dx);
         ne_cy_ff   <= 17'(req_y_pos) + 17'(req_circle_dy);
         ne_xe_ff   <= 17'(req_x_pos) + 17'(req_box_width);
         ne_ye_ff   <= 17'(req_y_pos) + 17'(req_box_height);
         ne_r2_ff   <= 24'(req_radius) * 24'(req_radius);
         ne_slot_ff <= cmd.slot[AW-1:0];
      end
      if (cmd.rd_en) begin
         rd_ff <= table_mem[cmd.rd_addr[AW-1:0]];
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      idx0_ff    <= cmd.rd_addr[AW-1:0];

      idx1_ff    <= idx0_ff;
      e1_box_ff  <= rd_ff.has_box;
      e1_circ_ff <= rd_ff.has_circle;
      e1_x_ff    <= rd_ff.x_pos;
      e1_y_ff    <= rd_ff.y_pos;
      e1_cx_ff   <= 17'(rd_ff.x_pos) + 17'(rd_ff.circle_dx);
      e1_cy_ff   <= 17'(rd_ff.y_pos) + 17'(rd_ff.circle_dy);
      e1_xe_ff   <= 17'(rd_ff.x_pos) + 17'(rd_ff.box_width);
      e1_ye_ff   <= 17'(rd_ff.y_pos) + 17'(rd_ff.box_height);
      e1_r_ff    <= rd_ff.radius;

      idx2_ff    <= idx1_ff;
      e2_box_ff  <= e1_box_ff;
      e2_circ_ff <= e1_circ_ff;
      e2_r_ff    <= e1_r_ff;
      cc_dx_ff   <= 18'(e1_cx_ff) - 18'(ne_cx_ff);
      cc_dy_ff   <= 18'(e1_cy_ff) - 18'(ne_cy_ff);
      rsum_ff    <= 13'(e1_r_ff) + 13'(ne_ff.radius);
      bb2_ff     <= (e1_x_ff <= ne_xe_ff) && (ne_ff.x_pos <= e1_xe_ff) &&
                    (e1_y_ff <= ne_ye_ff) && (ne_ff.y_pos <= e1_ye_ff);
      bc_dx_ff   <= clamp_gap(17'(e1_x_ff), e1_xe_ff, ne_cx_ff);
      bc_dy_ff   <= clamp_gap(17'(e1_y_ff), e1_ye_ff, ne_cy_ff);
      cb_dx_ff   <= clamp_gap(17'(ne_ff.x_pos), ne_xe_ff, e1_cx_ff);
      cb_dy_ff   <= clamp_gap(17'(ne_ff.y_pos), ne_ye_ff, e1_cy_ff);

      idx3_ff    <= idx2_ff;
      e3_box_ff  <= e2_box_ff;
      e3_circ_ff <= e2_circ_ff;
      bb3_ff     <= bb2_ff;
      cc_sx_ff   <= 36'(cc_dx_ff) * 36'(cc_dx_ff);
      cc_sy_ff   <= 36'(cc_dy_ff) * 36'(cc_dy_ff);
      bc_sx_ff   <= 36'(bc_dx_ff) * 36'(bc_dx_ff);
      bc_sy_ff   <= 36'(bc_dy_ff) * 36'(bc_dy_ff);
      cb_sx_ff   <= 36'(cb_dx_ff) * 36'(cb_dx_ff);
      cb_sy_ff   <= 36'(cb_dy_ff) * 36'(cb_dy_ff);
      rs2_ff     <= 26'(rsum_ff) * 26'(rsum_ff);
      er2_ff     <= 24'(e2_r_ff) * 24'(e2_r_ff);
   end

   // Final compares and kind priority.
   always_comb begin
      cc_hit = e3_circ_ff && ne_ff.has_circle &&
               ((37'(cc_sx_ff) + 37'(cc_sy_ff)) < 37'(rs2_ff));
      bb_hit = e3_box_ff && ne_ff.has_box && bb3_ff;
      bc_hit = e3_box_ff && ne_ff.has_circle &&
               ((37'(bc_sx_ff) + 37'(bc_sy_ff)) < 37'(ne_r2_ff));
      cb_hit = e3_circ_ff && ne_ff.has_box &&
               ((37'(cb_sx_ff) + 37'(cb_sy_ff)) < 37'(er2_ff));
      pair_hit = v3_ff && (cc_hit || bb_hit || bc_hit || cb_hit);
      if (cc_hit) begin
         pair_kind = KIND_CIRCLE_CIRCLE;
      end else if (bb_hit) begin
         pair_kind = KIND_BOX_BOX;
      end else if (bc_hit) begin
         pair_kind = KIND_BOX_CIRCLE;
      end else begin
         pair_kind = KIND_CIRCLE_BOX;
      end
   end

   // Result selection: a new hit pushes the held one out as a non-final result.
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      pend_kind_in  = pend_kind_ff;
      rsp_valid_in  = 1'b0;
      rsp_hit_in    = rsp_hit_ff;
      rsp_ei_in     = rsp_ei_ff;
      rsp_ni_in     = rsp_ni_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_drop_in   = rsp_drop_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.drop) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = 1'b0;
         rsp_ei_in    = '0;
         rsp_ni_in    = '0;
         rsp_kind_in  = KIND_CIRCLE_CIRCLE;
         rsp_drop_in  = 1'b1;
         rsp_last_in  = 1'b1;
      end else if (pair_hit) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_hit_in   = 1'b1;
            rsp_ei_in    = IDX_W'(pend_idx_ff);
            rsp_ni_in    = IDX_W'(ne_slot_ff);
            rsp_kind_in  = pend_kind_ff;
            rsp_drop_in  = 1'b0;
            rsp_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_idx_in   = idx3_ff;
         pend_kind_in  = pair_kind;
      end else if (cmd.finish) begin
         rsp_valid_in  = 1'b1;
         rsp_ni_in     = IDX_W'(ne_slot_ff);
         rsp_drop_in   = 1'b0;
         rsp_last_in   = 1'b1;
         pend_valid_in = 1'b0;
         if (pend_valid_ff) begin
            rsp_hit_in  = 1'b1;
            rsp_ei_in   = IDX_W'(pend_idx_ff);
            rsp_kind_in = pend_kind_ff;
         end else begin
            rsp_hit_in  = 1'b0;
            rsp_ei_in   = '0;
            rsp_kind_in = KIND_CIRCLE_CIRCLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff         <= 1'b0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         v0_ff         <= cmd.rd_en;
         v1_ff         <= v0_ff;
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff  <= pend_idx_in;
      pend_kind_ff <= pend_kind_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_ei_ff    <= rsp_ei_in;
      rsp_ni_ff    <= rsp_ni_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_drop_ff  <= rsp_drop_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign status.pipe_empty = !(v0_ff || v1_ff || v2_ff || v3_ff);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_earlier_index = rsp_ei_ff;
   assign rsp_new_index     = rsp_ni_ff;
   assign rsp_pair_kind     = rsp_kind_ff;
   assign rsp_dropped       = rsp_drop_ff;
   assign rsp_last_of_run   = rsp_last_ff;

endmodule
